// File: hw/rtl/pfr_pkg.sv
// Package for the primitive fill rasterizer: command and status types,
// mode and state codes, shared widths. Depends on nothing.
package pfr_pkg;

    // Signed working width for screen coordinates and edge vectors
    localparam int CRD_W = 11;
    // Width of one product of two coordinates
    localparam int PRD_W = 2 * CRD_W;
    // Pixel color index width
    localparam int PIX_W = 5;
    // Written-pixel count width, saturating
    localparam int CNT_W = 13;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        MODE_CLEAR  = 3'd0,
        MODE_PLOT   = 3'd1,
        MODE_RECT   = 3'd2,
        MODE_CIRCLE = 3'd3,
        MODE_TRI    = 3'd4,
        MODE_READ   = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_INIT_WAIT,
        ST_IDLE,
        ST_DRAW,
        ST_READ,
        ST_DONE
    } ctl_state_t;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_SETUP,
        RS_SCAN,
        RS_DRAIN
    } rs_state_t;

    // One drawing command handed to the rasterizer
    typedef struct packed {
        mode_t             mode;
        logic signed [7:0] row_a;
        logic signed [7:0] col_a;
        logic signed [7:0] row_b;
        logic signed [7:0] col_b;
        logic signed [7:0] row_c;
        logic signed [7:0] col_c;
        logic [5:0]        radius;
        logic [PIX_W-1:0]  color;
    } draw_cmd_t;

    // Rasterizer status back to the control
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } draw_stat_t;

endpackage

// File: hw/rtl/pfr_frame_mem.sv
// Framebuffer memory: SIDE*SIDE color indices, one write and one read port,
// registered read data. Depends on pfr_pkg.
module pfr_frame_mem #(
    parameter int SIDE = 64,
    localparam int AW = $clog2(SIDE * SIDE)
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [pfr_pkg::PIX_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [pfr_pkg::PIX_W-1:0] rd_data
);
    import pfr_pkg::*;

    localparam int DEPTH = SIDE * SIDE;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/pfr_raster.sv
// Rasterizer: sets up the clipped box of a command, scans it one pixel per
// cycle, tests coverage in a two-stage pipe and issues framebuffer writes.
// Depends on pfr_pkg.
module pfr_raster #(
    parameter int SIDE = 64,
    localparam int AW = $clog2(SIDE * SIDE)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  pfr_pkg::draw_cmd_t        cmd,
    output pfr_pkg::draw_stat_t       stat,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output logic [pfr_pkg::PIX_W-1:0] wr_data
);
    import pfr_pkg::*;

    localparam int CW = $clog2(SIDE);
    localparam logic signed [CRD_W-1:0] MAX_CRD = CRD_W'(SIDE - 1);

    function automatic logic signed [CRD_W-1:0] clip_lo(input logic signed [CRD_W-1:0] v);
        clip_lo = (v < 0) ? '0 : v;
    endfunction

    function automatic logic signed [CRD_W-1:0] clip_hi(input logic signed [CRD_W-1:0] v);
        clip_hi = (v > MAX_CRD) ? MAX_CRD : v;
    endfunction

    function automatic logic signed [CRD_W-1:0] min3(input logic signed [CRD_W-1:0] a,
                                                     input logic signed [CRD_W-1:0] b,
                                                     input logic signed [CRD_W-1:0] c);
        logic signed [CRD_W-1:0] m;
        m = (a < b) ? a : b;
        min3 = (m < c) ? m : c;
    endfunction

    function automatic logic signed [CRD_W-1:0] max3(input logic signed [CRD_W-1:0] a,
                                                     input logic signed [CRD_W-1:0] b,
                                                     input logic signed [CRD_W-1:0] c);
        logic signed [CRD_W-1:0] m;
        m = (a > b) ? a : b;
        max3 = (m > c) ? m : c;
    endfunction

    rs_state_t state_reg, state_next;
    draw_cmd_t cmd_reg;

    // setup results
    logic [CW-1:0] r_hi_reg, c_lo_reg, c_hi_reg;
    logic          empty_reg, empty_next;
    logic signed [CRD_W-1:0] e0r_reg, e0c_reg, e1r_reg, e1c_reg;
    logic signed [PRD_W-1:0] k_reg;
    logic [11:0]             rr_reg;

    // scan position
    logic [CW-1:0] cur_r_reg, cur_c_reg, cur_r_next, cur_c_next;

    // stage 1: products
    logic                    v1_reg, v1_next;
    logic [AW-1:0]           a1_reg;
    logic signed [PRD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg;

    // stage 2: write and count
    logic             w_en_reg, w_en_next;
    logic [AW-1:0]    w_addr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    // Setup arithmetic from the latched command
    logic signed [CRD_W-1:0] ra, ca, rb, cb, rc, cc, rad_s;
    logic signed [CRD_W-1:0] lo_r, hi_r, lo_c, hi_c;
    logic signed [CRD_W-1:0] clo_r, chi_r, clo_c, chi_c;
    logic signed [CRD_W-1:0] e0r_c, e0c_c, e1r_c, e1c_c;
    logic signed [PRD_W-1:0] ka, kb, k_c;
    logic [11:0]             rr_c;
    logic                    rev;

    always_comb begin
        ra    = CRD_W'(cmd_reg.row_a);
        ca    = CRD_W'(cmd_reg.col_a);
        rb    = CRD_W'(cmd_reg.row_b);
        cb    = CRD_W'(cmd_reg.col_b);
        rc    = CRD_W'(cmd_reg.row_c);
        cc    = CRD_W'(cmd_reg.col_c);
        rad_s = CRD_W'(cmd_reg.radius);
        e0c_c = cc - ca;
        e0r_c = rc - ra;
        e1c_c = cb - ca;
        e1r_c = rb - ra;
        ka    = e0c_c * e1r_c;
        kb    = e0r_c * e1c_c;
        k_c   = ka - kb;
        rr_c  = cmd_reg.radius * cmd_reg.radius;
        lo_r  = '0;
        hi_r  = MAX_CRD;
        lo_c  = '0;
        hi_c  = MAX_CRD;
        rev   = 1'b0;
        unique case (cmd_reg.mode)
            MODE_CLEAR: begin
                rev = 1'b0;
            end
            MODE_RECT: begin
                lo_r = ra;
                hi_r = rb;
                lo_c = ca;
                hi_c = cb;
                rev  = (ra > rb) || (ca > cb);
            end
            MODE_CIRCLE: begin
                lo_r = rc - rad_s;
                hi_r = rc + rad_s;
                lo_c = cc - rad_s;
                hi_c = cc + rad_s;
            end
            MODE_TRI: begin
                lo_r = min3(ra, rb, rc);
                hi_r = max3(ra, rb, rc);
                lo_c = min3(ca, cb, cc);
                hi_c = max3(ca, cb, cc);
                rev  = (k_c == '0);
            end
            default: begin
                rev = 1'b1;
            end
        endcase
        clo_r      = clip_lo(lo_r);
        chi_r      = clip_hi(hi_r);
        clo_c      = clip_lo(lo_c);
        chi_c      = clip_hi(hi_c);
        empty_next = rev || (clo_r > chi_r) || (clo_c > chi_c);
    end

    // Scan sequencer
    logic scan_v;

    always_comb begin
        state_next = state_reg;
        cur_r_next = cur_r_reg;
        cur_c_next = cur_c_reg;
        scan_v     = 1'b0;
        unique case (state_reg)
            RS_IDLE: begin
                if (start) begin
                    state_next = RS_SETUP;
                end
            end
            RS_SETUP: begin
                cur_r_next = clo_r[CW-1:0];
                cur_c_next = clo_c[CW-1:0];
                state_next = RS_SCAN;
            end
            RS_SCAN: begin
                if (empty_reg) begin
                    state_next = RS_DRAIN;
                end else begin
                    scan_v = 1'b1;
                    if (cur_c_reg == c_hi_reg) begin
                        cur_c_next = c_lo_reg;
                        if (cur_r_reg == r_hi_reg) begin
                            state_next = RS_DRAIN;
                        end else begin
                            cur_r_next = cur_r_reg + 1'b1;
                        end
                    end else begin
                        cur_c_next = cur_c_reg + 1'b1;
                    end
                end
            end
            RS_DRAIN: begin
                if (!v1_reg) begin
                    state_next = RS_IDLE;
                end
            end
            default: begin
                state_next = RS_IDLE;
            end
        endcase
    end

    // Stage 1 operands: squared offsets for a disc, edge crosses for a triangle
    logic signed [CRD_W-1:0] pr, pc, dr, dc, e2r, e2c;
    logic signed [CRD_W-1:0] m0a, m0b, m1a, m1b;
    logic signed [PRD_W-1:0] p0_next, p1_next, p2_next, p3_next;
    logic [AW-1:0]           a1_next;

    always_comb begin
        pr  = CRD_W'(cur_r_reg);
        pc  = CRD_W'(cur_c_reg);
        dr  = pr - rc;
        dc  = pc - cc;
        e2r = pr - ra;
        e2c = pc - ca;
        if (cmd_reg.mode == MODE_CIRCLE) begin
            m0a = dr;
            m0b = dr;
            m1a = dc;
            m1b = dc;
        end else begin
            m0a = e2c;
            m0b = e1r_reg;
            m1a = e2r;
            m1b = e1c_reg;
        end
        p0_next = m0a * m0b;
        p1_next = m1a * m1b;
        p2_next = e0c_reg * e2r;
        p3_next = e0r_reg * e2c;
        a1_next = AW'(cur_r_reg) * AW'(SIDE) + AW'(cur_c_reg);
        v1_next = scan_v;
    end

    // Stage 2: coverage decision and count
    logic signed [PRD_W:0]   sq_sum, rr_ext, u_val, v_val;
    logic signed [PRD_W+1:0] uv_sum, k_ext;
    logic                    hit;

    always_comb begin
        sq_sum = (PRD_W+1)'(p0_reg) + (PRD_W+1)'(p1_reg);
        rr_ext = (PRD_W+1)'(rr_reg);
        u_val  = (PRD_W+1)'(p0_reg) - (PRD_W+1)'(p1_reg);
        v_val  = (PRD_W+1)'(p2_reg) - (PRD_W+1)'(p3_reg);
        uv_sum = (PRD_W+2)'(u_val) + (PRD_W+2)'(v_val);
        k_ext  = (PRD_W+2)'(k_reg);
        unique case (cmd_reg.mode)
            MODE_CLEAR, MODE_RECT: begin
                hit = 1'b1;
            end
            MODE_CIRCLE: begin
                hit = (sq_sum <= rr_ext);
            end
            MODE_TRI: begin
                if (k_reg > 0) begin
                    hit = (u_val >= 0) && (v_val >= 0) && (uv_sum <= k_ext);
                end else begin
                    hit = (u_val <= 0) && (v_val <= 0) && (uv_sum >= k_ext);
                end
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        w_en_next  = v1_reg && hit;
        count_next = count_reg;
        if (state_reg == RS_IDLE && start) begin
            count_next = '0;
        end else if (w_en_next && count_reg != CNT_MAX) begin
            count_next = count_reg + 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RS_IDLE;
            v1_reg    <= 1'b0;
            w_en_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= v1_next;
            w_en_reg  <= w_en_next;
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == RS_IDLE && start) begin
            cmd_reg <= cmd;
        end
        if (state_reg == RS_SETUP) begin
            r_hi_reg  <= chi_r[CW-1:0];
            c_lo_reg  <= clo_c[CW-1:0];
            c_hi_reg  <= chi_c[CW-1:0];
            empty_reg <= empty_next;
            e0r_reg   <= e0r_c;
            e0c_reg   <= e0c_c;
            e1r_reg   <= e1r_c;
            e1c_reg   <= e1c_c;
            k_reg     <= k_c;
            rr_reg    <= rr_c;
        end
        cur_r_reg  <= cur_r_next;
        cur_c_reg  <= cur_c_next;
        a1_reg     <= a1_next;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        p3_reg     <= p3_next;
        w_addr_reg <= a1_reg;
    end

    assign stat.busy  = (state_reg != RS_IDLE);
    assign stat.count = count_reg;
    assign wr_en      = w_en_reg;
    assign wr_addr    = w_addr_reg;
    assign wr_data    = cmd_reg.color;

endmodule

// File: hw/rtl/primitive_fill_rasterizer_unit.sv
// Primitive fill rasterizer, top level: stream ports, command control,
// read path and result register. Depends on pfr_pkg, pfr_raster, pfr_frame_mem.
// Drawing scans the clipped box of a rect, disc or triangle, or the whole
// SIDE*SIDE screen for clear, one pixel per cycle.
// Throughput: one command at a time; the rasterizer's single write port sets the rate.
// Reset: clears the framebuffer to zero with a SIDE*SIDE sweep,
// s_tready stays low until it completes.
module primitive_fill_rasterizer_unit #(
    parameter int SIDE = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row_a[7:0] col_a[15:8] row_b[23:16] col_b[31:24] row_c[39:32] col_c[47:40]
    // radius[53:48] color[58:54], rest zero
    input  logic [63:0] s_tdata,
    // mode[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_color[4:0] pixels_written[17:5] outside[18], rest zero
    output logic [23:0] m_tdata
);
    import pfr_pkg::*;

    localparam int AW = $clog2(SIDE * SIDE);
    localparam int CW = $clog2(SIDE);
    localparam int OUT_BIT = PIX_W + CNT_W;
    localparam logic signed [CRD_W-1:0] MAX_CRD = CRD_W'(SIDE - 1);

    // Unpack the input beat
    draw_cmd_t in_cmd;
    logic signed [CRD_W-1:0] pt_r, pt_c;
    logic pt_on;

    always_comb begin
        in_cmd.mode   = mode_t'(s_tuser);
        in_cmd.row_a  = s_tdata[7:0];
        in_cmd.col_a  = s_tdata[15:8];
        in_cmd.row_b  = s_tdata[23:16];
        in_cmd.col_b  = s_tdata[31:24];
        in_cmd.row_c  = s_tdata[39:32];
        in_cmd.col_c  = s_tdata[47:40];
        in_cmd.radius = s_tdata[53:48];
        in_cmd.color  = s_tdata[58:54];
        pt_r  = CRD_W'(in_cmd.row_a);
        pt_c  = CRD_W'(in_cmd.col_a);
        pt_on = (pt_r >= 0) && (pt_r <= MAX_CRD) && (pt_c >= 0) && (pt_c <= MAX_CRD);
    end

    ctl_state_t       state_reg, state_next;
    draw_cmd_t        rast_cmd;
    draw_stat_t       rast_stat;
    logic             rast_start;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [PIX_W-1:0] rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [PIX_W-1:0] wr_data;

    logic [PIX_W-1:0] res_pix_reg, res_pix_next;
    logic [CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic             res_out_reg, res_out_next;
    logic             m_load;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [23:0]      m_tdata_reg;

    assign rd_addr = AW'(pt_r[CW-1:0]) * AW'(SIDE) + AW'(pt_c[CW-1:0]);

    // Command control
    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        rast_start   = 1'b0;
        rast_cmd     = in_cmd;
        rd_en        = 1'b0;
        m_load       = 1'b0;
        res_pix_next = res_pix_reg;
        res_cnt_next = res_cnt_reg;
        res_out_next = res_out_reg;
        unique case (state_reg)
            ST_INIT: begin
                rast_start     = 1'b1;
                rast_cmd.mode  = MODE_CLEAR;
                rast_cmd.color = '0;
                state_next     = ST_INIT_WAIT;
            end
            ST_INIT_WAIT: begin
                if (!rast_stat.busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    res_pix_next = '0;
                    res_cnt_next = '0;
                    res_out_next = 1'b0;
                    unique case (in_cmd.mode)
                        MODE_CLEAR, MODE_RECT, MODE_CIRCLE, MODE_TRI: begin
                            rast_start = 1'b1;
                            state_next = ST_DRAW;
                        end
                        MODE_PLOT: begin
                            // a plot is a one-pixel box
                            rast_start     = 1'b1;
                            rast_cmd.mode  = MODE_RECT;
                            rast_cmd.row_b = in_cmd.row_a;
                            rast_cmd.col_b = in_cmd.col_a;
                            res_out_next   = !pt_on;
                            state_next     = ST_DRAW;
                        end
                        MODE_READ: begin
                            if (pt_on) begin
                                rd_en      = 1'b1;
                                state_next = ST_READ;
                            end else begin
                                res_out_next = 1'b1;
                                state_next   = ST_DONE;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DRAW: begin
                if (!rast_stat.busy) begin
                    res_cnt_next = rast_stat.count;
                    state_next   = ST_DONE;
                end
            end
            ST_READ: begin
                res_pix_next = rd_data;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_tvalid_next = m_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_pix_reg <= res_pix_next;
        res_cnt_reg <= res_cnt_next;
        res_out_reg <= res_out_next;
        if (m_load) begin
            m_tdata_reg <= {5'b0, res_out_reg, res_cnt_reg, res_pix_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    pfr_raster #(
        .SIDE (SIDE)
    ) u_raster (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rast_start),
        .cmd     (rast_cmd),
        .stat    (rast_stat),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    pfr_frame_mem #(
        .SIDE (SIDE)
    ) u_frame_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

`ifndef SYNTHESIS
    // no beat is taken while the rasterizer still writes
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !rast_stat.busy)
        else $error("input accepted while rasterizer busy");

    // reads never overlap rasterizer writes
    a_read_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !rast_stat.busy)
        else $error("framebuffer read during drawing");

    // read data is captured only in the cycle after a read was issued
    a_read_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> $past(rd_en))
        else $error("read capture without a read");

    // an off-screen point never reports written pixels
    a_out_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[OUT_BIT]) |-> (m_tdata[OUT_BIT-1:PIX_W] == '0))
        else $error("outside flag with nonzero count");
`endif

endmodule

// File: verif/pfr_checker.sv
// Checker for the primitive fill rasterizer: watches both stream channels,
// keeps a shadow framebuffer, predicts each result and compares. Depends on pfr_pkg.
module pfr_checker #(
    parameter int SIDE = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pfr_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [CNT_W-1:0] cnt;
        logic             outside;
    } draw_result_t;

    logic [PIX_W-1:0] shadow_fb [SIDE*SIDE];
    draw_result_t     result_q [$];

    function automatic bit on_scr(int r, int c);
        return r >= 0 && r < SIDE && c >= 0 && c < SIDE;
    endfunction

    // Paint one pixel when on screen, bump the count
    function automatic void paint(int r, int c, logic [PIX_W-1:0] col, ref int cnt);
        if (on_scr(r, c)) begin
            shadow_fb[r*SIDE + c] = col;
            cnt++;
        end
    endfunction

    function automatic draw_result_t rasterize(logic [2:0] mode, logic [63:0] d);
        draw_result_t res;
        int ra, ca, rb, cb, rc, cc, rad, cnt;
        longint e0c, e0r, e1c, e1r, e2c, e2r, d00, d01, d02, d11, d12, den, un, vn;
        logic [PIX_W-1:0] col;
        ra = int'($signed(d[7:0]));   ca = int'($signed(d[15:8]));
        rb = int'($signed(d[23:16])); cb = int'($signed(d[31:24]));
        rc = int'($signed(d[39:32])); cc = int'($signed(d[47:40]));
        rad = int'(d[53:48]); col = d[58:54];
        res = '0; cnt = 0;
        case (mode)
            MODE_CLEAR: begin
                foreach (shadow_fb[i]) shadow_fb[i] = col;
                cnt = SIDE*SIDE;
            end
            MODE_PLOT, MODE_READ: begin
                if (!on_scr(ra, ca)) res.outside = 1'b1;
                else if (mode == MODE_PLOT) paint(ra, ca, col, cnt);
                else res.pix = shadow_fb[ra*SIDE + ca];
            end
            MODE_RECT: begin
                if (ra <= rb && ca <= cb)
                    for (int r = ra; r <= rb; r++)
                        for (int c = ca; c <= cb; c++) paint(r, c, col, cnt);
            end
            MODE_CIRCLE: begin
                for (int r = rc - rad; r <= rc + rad; r++)
                    for (int c = cc - rad; c <= cc + rad; c++)
                        if ((r-rc)*(r-rc) + (c-cc)*(c-cc) <= rad*rad)
                            paint(r, c, col, cnt);
            end
            MODE_TRI: begin
                e0c = cc - ca; e0r = rc - ra; e1c = cb - ca; e1r = rb - ra;
                d00 = e0c*e0c + e0r*e0r; d01 = e0c*e1c + e0r*e1r;
                d11 = e1c*e1c + e1r*e1r; den = d00*d11 - d01*d01;
                if (den > 0)
                    for (int r = -128; r < 128; r++) begin
                        if (r < 0 || r >= SIDE) continue;
                        for (int c = 0; c < SIDE; c++) begin
                            if (r < ra && r < rb && r < rc) continue;
                            if (r > ra && r > rb && r > rc) continue;
                            if (c < ca && c < cb && c < cc) continue;
                            if (c > ca && c > cb && c > cc) continue;
                            e2c = c - ca; e2r = r - ra;
                            d02 = e0c*e2c + e0r*e2r; d12 = e1c*e2c + e1r*e2r;
                            un = d11*d02 - d01*d12; vn = d00*d12 - d01*d02;
                            if (un >= 0 && vn >= 0 && un + vn <= den) paint(r, c, col, cnt);
                        end
                    end
            end
            default: ;
        endcase
        res.cnt = (cnt > int'(CNT_MAX)) ? CNT_MAX : cnt[CNT_W-1:0];
        return res;
    endfunction

    // Predict on every input beat, compare on every result beat
    always @(posedge aclk) begin
        draw_result_t want, got;
        if (!aresetn) begin
            foreach (shadow_fb[i]) shadow_fb[i] = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[4:0], m_tdata[17:5], m_tdata[18]};
                if (result_q.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (want.pix !== got.pix || m_tdata[23:19] !== '0)
                        $display("%0t: pixel_color expected %0d actual %0d",
                                 $time, want.pix, got.pix);
                    if (want.cnt !== got.cnt)
                        $display("%0t: pixels_written expected %0d actual %0d",
                                 $time, want.cnt, got.cnt);
                    if (want.outside !== got.outside)
                        $display("%0t: outside expected %0d actual %0d",
                                 $time, want.outside, got.outside);
                    if (want !== got || m_tdata[23:19] !== '0) fail_count++;
                end
            end
            if (s_tvalid && s_tready) result_q.push_back(rasterize(s_tuser, s_tdata));
        end
        pending = result_q.size();
    end
endmodule

// File: verif/tb_top.sv
// Testbench top for the primitive fill rasterizer: clock, reset, directed and
// random command beats, random backpressure. Depends on pfr_pkg, pfr_checker, the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pfr_pkg::*;

    localparam int SIDE = 64;
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready, m_tvalid, m_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic [23:0] m_tdata;
    int          fail_count, pending;
    bit          hold_off;
    longint      cycles;

    primitive_fill_rasterizer_unit #(.SIDE(SIDE)) u_dut (.*);

    pfr_checker #(.SIDE(SIDE)) u_chk (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // Pack one command beat
    function automatic logic [63:0] cmd(int ra, int ca, int rb, int cb, int rc, int cc,
                                        int rad, int col);
        logic [63:0] d;
        d = '0;
        d[7:0] = 8'(ra); d[15:8] = 8'(ca); d[23:16] = 8'(rb); d[31:24] = 8'(cb);
        d[39:32] = 8'(rc); d[47:40] = 8'(cc); d[53:48] = 6'(rad); d[58:54] = 5'(col);
        return d;
    endfunction

    // Idle a random gap, then hold the beat until it is taken
    task automatic send(logic [2:0] mode, logic [63:0] d);
        int gap;
        gap = $urandom_range(0, 15);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1; s_tuser <= mode; s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Mostly small, on-screen-ish coordinates; sometimes anything
    function automatic int crd();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 255);
        return $urandom_range(0, 79) - 8;
    endfunction

    task automatic send_random();
        int m, ra, ca;
        logic [63:0] d;
        m = $urandom_range(0, 7);
        ra = crd(); ca = crd();
        // Keep boxes small so the run stays short
        if (m == MODE_CLEAR && $urandom_range(0, 3) != 0) m = MODE_READ;
        d = cmd(ra, ca, ra + $urandom_range(0, 12) - 2, ca + $urandom_range(0, 12) - 2,
                crd(), crd(), $urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                : $urandom_range(0, 8), $urandom_range(0, 31));
        // padding bits set now and then
        if ($urandom_range(0, 15) == 0) d[63:59] = 5'h1f;
        send(m[2:0], d);
    endtask

    // Receiver: random gap per beat, one long hold-off on request
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_off = 0;
            end
            gap = $urandom_range(0, 15);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Cycle limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        aresetn = 1'b0; hold_off = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // Directed: each mode, extremes, reversed boxes, degenerate triangles
        send(MODE_READ, cmd(0, 0, 0, 0, 0, 0, 0, 0));
        send(MODE_PLOT, cmd(0, 0, 0, 0, 0, 0, 0, 31));
        send(MODE_PLOT, cmd(63, 63, 0, 0, 0, 0, 0, 21));
        send(MODE_PLOT, cmd(-128, 127, 0, 0, 0, 0, 0, 7));
        send(MODE_PLOT, cmd(64, 5, 0, 0, 0, 0, 0, 7));
        send(MODE_READ, cmd(0, 0, 0, 0, 0, 0, 0, 0));
        send(MODE_READ, cmd(63, 63, 0, 0, 0, 0, 0, 0));
        send(MODE_READ, cmd(127, -1, 0, 0, 0, 0, 0, 0));
        send(MODE_RECT, cmd(-128, -128, 127, 127, 0, 0, 0, 3));
        send(MODE_RECT, cmd(10, 10, 9, 20, 0, 0, 0, 4));
        send(MODE_RECT, cmd(10, 10, 20, 9, 0, 0, 0, 4));
        send(MODE_RECT, cmd(5, 5, 5, 5, 0, 0, 0, 9));
        send(MODE_CIRCLE, cmd(0, 0, 0, 0, 32, 32, 63, 12));
        send(MODE_CIRCLE, cmd(0, 0, 0, 0, -128, 127, 0, 12));
        send(MODE_CIRCLE, cmd(0, 0, 0, 0, 3, 60, 5, 13));
        send(MODE_TRI, cmd(0, 0, 63, 0, 0, 63, 0, 17));
        send(MODE_TRI, cmd(-128, -128, 127, -128, -128, 127, 0, 18));
        send(MODE_TRI, cmd(1, 1, 5, 5, 9, 9, 0, 19));
        send(MODE_TRI, cmd(4, 4, 4, 4, 4, 4, 0, 19));
        send(MODE_TRI, cmd(10, 2, 3, 8, 12, 12, 0, 20));
        send(3'd6, cmd(1, 1, 1, 1, 1, 1, 1, 1));
        send(3'd7, cmd(-1, -1, -1, -1, -1, -1, 63, 31));
        send(MODE_READ, cmd(10, 10, 0, 0, 0, 0, 0, 0));
        send(MODE_CLEAR, cmd(0, 0, 0, 0, 0, 0, 0, 0));
        // Long receiver hold-off while commands keep coming
        hold_off = 1;
        repeat (8) send(MODE_PLOT, cmd(crd(), crd(), 0, 0, 0, 0, 0, $urandom_range(0, 31)));
        repeat (108) send_random();
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
